// ===== rtl/pidt_pkg.sv =====
// Shared widths, constants, payload structs and fixed-point helpers for the
// PID twiddle tuner. No dependencies.
package pidt_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 32;
    localparam int SUM_W     = 48;
    localparam int INTEG_W   = SAMPLE_W + 16;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int COUNT_W   = 16;
    localparam int PHASE_W   = COUNT_W + 1;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_CNT  = 3;
    localparam int FRAC      = 16;
    localparam int K_W       = 17;
    localparam int SCL_W     = GAIN_W + K_W + 1;
    localparam int ACC_W     = 64;
    localparam int HALF_LSB  = 1 << (FRAC - 1);

    localparam logic [K_W-1:0] K_TENTH  = 17'd6554;
    localparam logic [K_W-1:0] K_GROW   = 17'd72090;
    localparam logic [K_W-1:0] K_SHRINK = 17'd58982;

    localparam logic [COUNT_W-1:0] SETTLE_RST = 16'd100;
    localparam logic [COUNT_W-1:0] EVAL_RST   = 16'd2000;

    localparam logic [1:0] IDX_P = 2'd0;
    localparam logic [1:0] IDX_I = 2'd1;
    localparam logic [1:0] IDX_D = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P = 3'd0,
        REG_GAIN_I = 3'd1,
        REG_GAIN_D = 3'd2,
        REG_SETTLE = 3'd3,
        REG_EVAL   = 3'd4
    } cfg_reg_t;

    typedef logic signed [GAIN_W-1:0] gain_t;

    localparam gain_t GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam gain_t GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

    typedef struct packed {
        logic       tuned;
        logic [1:0] index;
        gain_t      gain_p;
        gain_t      gain_i;
        gain_t      gain_d;
    } pidt_status_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] e;
        logic signed [INTEG_W-1:0]  integ;
        logic signed [DIFF_W-1:0]   diff;
        pidt_status_t               status;
    } pidt_word_t;

    function automatic gain_t sat_gain(input logic signed [GAIN_W+1:0] x);
        if (x[GAIN_W+1:GAIN_W-1] == {3{x[GAIN_W-1]}})
            return x[GAIN_W-1:0];
        else
            return x[GAIN_W+1] ? GAIN_MIN : GAIN_MAX;
    endfunction

    // v * k with k in Q1.16, round half up, saturate to gain width
    function automatic gain_t scale_gain(input gain_t v, input logic [K_W-1:0] k);
        logic signed [SCL_W-1:0] prod;
        logic signed [SCL_W-1:0] rnd;
        prod = SCL_W'(v) * SCL_W'($signed({1'b0, k}));
        rnd  = prod + SCL_W'(HALF_LSB);
        return sat_gain(rnd[FRAC +: GAIN_W+2]);
    endfunction

endpackage

// ===== rtl/pidt_in_if.sv =====
// Error sample channel: valid/ready handshake carrying one sample word.
// Depends on pidt_pkg.
interface pidt_in_if
    import pidt_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] error_sample;

    modport source (output valid, output error_sample, input ready);
    modport sink   (input valid, input error_sample, output ready);
endinterface

// ===== rtl/pidt_out_if.sv =====
// Result channel: drive value, tuning flag and current gains.
// Depends on pidt_pkg.
interface pidt_out_if
    import pidt_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] drive;
    logic                       tuned;
    logic [1:0]                 tuned_index;
    gain_t                      gain_p_now;
    gain_t                      gain_i_now;
    gain_t                      gain_d_now;

    modport source (output valid, output drive, output tuned, output tuned_index,
                    output gain_p_now, output gain_i_now, output gain_d_now,
                    input ready);
    modport sink   (input valid, input drive, input tuned, input tuned_index,
                    input gain_p_now, input gain_i_now, input gain_d_now,
                    output ready);
endinterface

// ===== rtl/pidt_drive.sv =====
// Drive datapath: operand register, three gain products, sum, negate/round/saturate.
// Four elastic stages with per-stage valid. Depends on pidt_pkg, pidt_out_if.
module pidt_drive
    import pidt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pidt_word_t in_word,
    pidt_out_if.source result_ch
);

    localparam int PE_W = GAIN_W + SAMPLE_W;
    localparam int PI_W = GAIN_W + INTEG_W;
    localparam int PD_W = GAIN_W + DIFF_W;
    localparam int Q_W  = ACC_W - FRAC;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    pidt_word_t   s1_reg;
    pidt_status_t st2_reg, st3_reg, st4_reg;

    logic signed [PE_W-1:0] pe_next, pe_reg;
    logic signed [PI_W-1:0] pi_next, pi_reg;
    logic signed [PD_W-1:0] pd_next, pd_reg;
    logic [ACC_W-1:0]       acc_next, acc_reg;
    logic [ACC_W-1:0]       neg_rnd;
    logic [Q_W-1:0]         q;
    logic signed [SAMPLE_W-1:0] drive_next, drive_reg;

    assign r4 = !v4_reg || result_ch.ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_comb
    begin
        pe_next = $signed(s1_reg.status.gain_p) * $signed(s1_reg.e);
        pi_next = $signed(s1_reg.status.gain_i) * $signed(s1_reg.integ);
        pd_next = $signed(s1_reg.status.gain_d) * $signed(s1_reg.diff);
    end

    // sum cannot overflow 64 bits at these widths
    assign acc_next = {{(ACC_W-PE_W){pe_reg[PE_W-1]}}, pe_reg} + pi_reg
                    + {{(ACC_W-PD_W){pd_reg[PD_W-1]}}, pd_reg};

    // -acc + half LSB, then floor shift by FRAC
    assign neg_rnd = ~acc_reg + ACC_W'(HALF_LSB + 1);
    assign q       = neg_rnd[ACC_W-1:FRAC];

    always_comb
    begin
        if (q[Q_W-1:SAMPLE_W-1] == {(Q_W-SAMPLE_W+1){q[Q_W-1]}})
            drive_next = q[SAMPLE_W-1:0];
        else
            drive_next = q[Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
            s1_reg <= in_word;
        if (r2 && v1_reg)
        begin
            pe_reg  <= pe_next;
            pi_reg  <= pi_next;
            pd_reg  <= pd_next;
            st2_reg <= s1_reg.status;
        end
        if (r3 && v2_reg)
        begin
            acc_reg <= acc_next;
            st3_reg <= st2_reg;
        end
        if (r4 && v3_reg)
        begin
            drive_reg <= drive_next;
            st4_reg   <= st3_reg;
        end
    end

    assign result_ch.valid       = v4_reg;
    assign result_ch.drive       = drive_reg;
    assign result_ch.tuned       = st4_reg.tuned;
    assign result_ch.tuned_index = st4_reg.index;
    assign result_ch.gain_p_now  = st4_reg.gain_p;
    assign result_ch.gain_i_now  = st4_reg.gain_i;
    assign result_ch.gain_d_now  = st4_reg.gain_d;

endmodule

// ===== rtl/pid_with_twiddle_autotune.sv =====
// PID controller with twiddle gain tuning. Tuner state updates in the cycle a
// word is accepted; the drive path behind it is four register stages.
// Throughput: one word per cycle; the input stalls only when all four stages
// hold words and the result side is not ready.
// Reset (rst_n, async low) empties the pipeline and restores start registers and
// tuner state; a config write to any defined register (index 0 to 4) re-initializes the tuner.
module pid_with_twiddle_autotune
    import pidt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pidt_in_if.sink              sample_ch,
    pidt_out_if.source           result_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    gain_t start_reg [GAIN_CNT];
    gain_t start_new [GAIN_CNT];
    gain_t gains_reg [GAIN_CNT];
    gain_t gains_next [GAIN_CNT];
    gain_t deltas_reg [GAIN_CNT];
    gain_t deltas_next [GAIN_CNT];
    gain_t scaled [GAIN_CNT];
    gain_t gain_plus [GAIN_CNT];
    gain_t gain_minus2 [GAIN_CNT];

    logic [COUNT_W-1:0]         settle_reg, settle_next;
    logic [COUNT_W-1:0]         eval_reg, eval_next;
    logic signed [SAMPLE_W-1:0] last_err_reg, last_err_next;
    logic signed [INTEG_W-1:0]  integ_reg, integ_next;
    logic [SUM_W-1:0]           sq_sum_reg, sq_sum_next;
    logic [SUM_W-1:0]           best_reg, best_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next, period;
    logic                       first_sample_reg, first_sample_next;
    logic                       first_period_reg, first_period_next;
    logic                       went_up_reg, went_up_next;
    logic [1:0]                 tune_idx_reg, tune_idx_next, idx, nidx;

    logic [GAIN_CNT-1:0]        wr_gain;
    logic                       wr_settle, wr_eval, cfg_init;
    logic                       accept, word_ready, period_end, better;
    logic signed [SAMPLE_W-1:0] e;
    logic signed [DIFF_W-1:0]   diff;
    logic [INTEG_W:0]           integ_sum;
    logic signed [2*SAMPLE_W-1:0] sq;
    logic [SUM_W:0]             sq_add;
    pidt_word_t                 word;

    assign e      = sample_ch.error_sample;
    assign accept = sample_ch.valid && word_ready;
    assign sample_ch.ready = word_ready;

    always_comb
    begin
        wr_gain   = '0;
        wr_settle = 1'b0;
        wr_eval   = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_P: wr_gain[IDX_P] = 1'b1;
                REG_GAIN_I: wr_gain[IDX_I] = 1'b1;
                REG_GAIN_D: wr_gain[IDX_D] = 1'b1;
                REG_SETTLE: wr_settle      = 1'b1;
                REG_EVAL:   wr_eval        = 1'b1;
                default:    ;
            endcase
        end
    end

    assign cfg_init = (|wr_gain) || wr_settle || wr_eval;

    // per-sample arithmetic
    assign diff = first_sample_reg ? '0
                : $signed({e[SAMPLE_W-1], e}) - $signed({last_err_reg[SAMPLE_W-1], last_err_reg});
    assign integ_sum = {integ_reg[INTEG_W-1], integ_reg}
                     + {{(INTEG_W+1-SAMPLE_W){e[SAMPLE_W-1]}}, e};
    assign sq     = e * e;
    assign sq_add = {1'b0, sq_sum_reg} + {{(SUM_W+1-2*SAMPLE_W){1'b0}}, sq};
    assign period = PHASE_W'(settle_reg)
                  + PHASE_W'((eval_reg == '0) ? COUNT_W'(1) : eval_reg);
    assign period_end = phase_reg >= period;
    assign better     = sq_sum_reg < best_reg;
    assign idx        = (tune_idx_reg > IDX_D) ? IDX_D : tune_idx_reg;
    assign nidx       = (idx == IDX_D) ? IDX_P : idx + 2'd1;

    always_comb
    begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
            integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
        else
            integ_next = integ_sum[INTEG_W-1:0];
    end

    // one scale multiplier per gain lane: init tenth on config, grow/shrink on tune
    always_comb
    begin
        for (int k = 0; k < GAIN_CNT; k++)
        begin
            start_new[k]   = wr_gain[k] ? gain_t'(cfg_data) : start_reg[k];
            scaled[k]      = scale_gain(cfg_init ? start_new[k] : deltas_reg[k],
                                        cfg_init ? K_TENTH : (better ? K_GROW : K_SHRINK));
            gain_plus[k]   = sat_gain((GAIN_W+2)'(gains_reg[k]) + (GAIN_W+2)'(deltas_reg[k]));
            gain_minus2[k] = sat_gain((GAIN_W+2)'(gains_reg[k])
                                      - ((GAIN_W+2)'(deltas_reg[k]) <<< 1));
        end
    end

    always_comb
    begin
        settle_next       = settle_reg;
        eval_next         = eval_reg;
        last_err_next     = last_err_reg;
        sq_sum_next       = sq_sum_reg;
        best_next         = best_reg;
        phase_next        = phase_reg;
        first_sample_next = first_sample_reg;
        first_period_next = first_period_reg;
        went_up_next      = went_up_reg;
        tune_idx_next     = tune_idx_reg;
        for (int k = 0; k < GAIN_CNT; k++)
        begin
            gains_next[k]  = gains_reg[k];
            deltas_next[k] = deltas_reg[k];
        end

        if (cfg_init)
        begin
            if (wr_settle) settle_next = cfg_data[COUNT_W-1:0];
            if (wr_eval)   eval_next   = cfg_data[COUNT_W-1:0];
            last_err_next     = '0;
            sq_sum_next       = '0;
            best_next         = '1;
            phase_next        = PHASE_W'(1);
            first_sample_next = 1'b1;
            first_period_next = 1'b1;
            went_up_next      = 1'b0;
            tune_idx_next     = IDX_D;
            for (int k = 0; k < GAIN_CNT; k++)
            begin
                gains_next[k]  = start_new[k];
                deltas_next[k] = scaled[k];
            end
        end
        else if (accept)
        begin
            first_sample_next = 1'b0;
            last_err_next     = e;
            if (period_end)
            begin
                for (int k = 0; k < GAIN_CNT; k++)
                begin
                    if (better)
                    begin
                        if (2'(k) == idx && !first_period_reg) deltas_next[k] = scaled[k];
                        if (2'(k) == nidx) gains_next[k] = gain_plus[k];
                    end
                    else if (went_up_reg)
                    begin
                        if (2'(k) == idx) gains_next[k] = gain_minus2[k];
                    end
                    else
                    begin
                        if (2'(k) == idx)
                        begin
                            gains_next[k]  = gain_plus[k];
                            deltas_next[k] = scaled[k];
                        end
                        if (2'(k) == nidx) gains_next[k] = gain_plus[k];
                    end
                end
                if (better) best_next = sq_sum_reg;
                went_up_next      = better || !went_up_reg;
                tune_idx_next     = (!better && went_up_reg) ? idx : nidx;
                sq_sum_next       = '0;
                first_period_next = 1'b0;
                phase_next        = PHASE_W'(1);
            end
            else
            begin
                if (phase_reg > PHASE_W'(settle_reg))
                    sq_sum_next = sq_add[SUM_W] ? '1 : sq_add[SUM_W-1:0];
                phase_next = phase_reg + PHASE_W'(1);
            end
        end
    end

    always_comb
    begin
        word.e             = e;
        word.integ         = integ_next;
        word.diff          = diff;
        word.status.tuned  = period_end;
        word.status.index  = tune_idx_next;
        word.status.gain_p = gains_next[IDX_P];
        word.status.gain_i = gains_next[IDX_I];
        word.status.gain_d = gains_next[IDX_D];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg       <= SETTLE_RST;
            eval_reg         <= EVAL_RST;
            last_err_reg     <= '0;
            integ_reg        <= '0;
            sq_sum_reg       <= '0;
            best_reg         <= '1;
            phase_reg        <= PHASE_W'(1);
            first_sample_reg <= 1'b1;
            first_period_reg <= 1'b1;
            went_up_reg      <= 1'b0;
            tune_idx_reg     <= IDX_D;
            for (int k = 0; k < GAIN_CNT; k++)
            begin
                start_reg[k]  <= '0;
                gains_reg[k]  <= '0;
                deltas_reg[k] <= '0;
            end
        end
        else
        begin
            settle_reg       <= settle_next;
            eval_reg         <= eval_next;
            last_err_reg     <= last_err_next;
            sq_sum_reg       <= sq_sum_next;
            best_reg         <= best_next;
            phase_reg        <= phase_next;
            first_sample_reg <= first_sample_next;
            first_period_reg <= first_period_next;
            went_up_reg      <= went_up_next;
            tune_idx_reg     <= tune_idx_next;
            if (cfg_init)
                integ_reg <= '0;
            else if (accept)
                integ_reg <= integ_next;
            for (int k = 0; k < GAIN_CNT; k++)
            begin
                start_reg[k]  <= start_new[k];
                gains_reg[k]  <= gains_next[k];
                deltas_reg[k] <= deltas_next[k];
            end
        end
    end

    pidt_drive u_drive (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (word_ready),
        .in_word   (word),
        .result_ch (result_ch)
    );

endmodule

// ===== rtl/pidt_checker.sv =====
// Port-level checks for the PID twiddle tuner, bound to the top level.
// Depends on pidt_pkg.
module pidt_checker
    import pidt_pkg::*;
#(
    parameter int OUT_W = SAMPLE_W + 3 + 3 * GAIN_W
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [1:0]       out_index,
    input logic [OUT_W-1:0] out_word
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // with the sink ready, an accepted word reaches the result port
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("accepted word did not reach the result port");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_index == IDX_P || out_index == IDX_I || out_index == IDX_D))
        else $error("tuned index out of range");

    // reset clears the result stage by the next edge
    a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind pid_with_twiddle_autotune pidt_checker u_pidt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_index (result_ch.tuned_index),
    .out_word  ({result_ch.drive, result_ch.tuned, result_ch.tuned_index,
                 result_ch.gain_p_now, result_ch.gain_i_now, result_ch.gain_d_now})
);
